// ----- hw/rtl/quintic_bezier_eval_macros.svh -----
// Assertion macros for the quintic Bezier evaluator.
`ifndef QUINTIC_BEZIER_EVAL_MACROS_SVH
`define QUINTIC_BEZIER_EVAL_MACROS_SVH

`ifndef SYNTHESIS
`define QBE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("qbe assertion failed");
`define QBE_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("qbe assertion failed");
`else
`define QBE_ASSERT(lbl, clk, rstn, prop)
`define QBE_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

// ----- hw/rtl/qbe_pkg.sv -----
`timescale 1ns / 1ps

package qbe_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int T_W          = FRAC_BITS + 1;
  localparam int PT_W         = 32;
  localparam int SLOPE_W      = 36;
  localparam int NUM_PTS      = 6;
  localparam int NUM_CELLS    = NUM_PTS - 1;
  localparam int CFG_IDX_W    = 3;
  localparam int POW_W        = FRAC_BITS + 1;
  localparam int WGT_W        = POW_W + 4;
  // signed weight times signed point difference
  localparam int PROD_W       = WGT_W + PT_W + 2;
  // six-term sum, then times five
  localparam int ACC_W        = PROD_W + 6;
  localparam int BLEND_STAGES = 7;

  localparam logic [POW_W-1:0] ONE = POW_W'(1) << FRAC_BITS;

  localparam logic [3:0] BINOM5 [NUM_PTS]   = '{4'd1, 4'd5, 4'd10, 4'd10, 4'd5, 4'd1};
  localparam logic [3:0] BINOM4 [NUM_PTS-1] = '{4'd1, 4'd4, 4'd6, 4'd4, 4'd1};

  typedef logic [POW_W-1:0] pow_t;

  // powers travel as shift lines: index 0 holds the newest power
  typedef struct packed {
    pow_t                 t;
    pow_t                 u;
    pow_t [NUM_PTS-1:0]   tp;
    pow_t [NUM_PTS-1:0]   up;
  } pow_stage_t;

  typedef logic [NUM_PTS-1:0][PT_W-1:0] pts_t;

  // a*b rounded to nearest, ties up; both operands at most 1.0
  function automatic pow_t umul_round(pow_t a, pow_t b);
    logic [2*POW_W-1:0] prod;
    prod = {{POW_W{1'b0}}, a} * {{POW_W{1'b0}}, b}
         + ((2*POW_W)'(1) << (FRAC_BITS - 1));
    return prod[FRAC_BITS +: POW_W];
  endfunction

endpackage

// ----- hw/rtl/qbe_in_if.sv -----
`timescale 1ns / 1ps

interface qbe_in_if;
  import qbe_pkg::*;

  logic           valid;
  logic           ready;
  logic [T_W-1:0] param_t;

  modport source (output valid, output param_t, input ready);
  modport sink   (input valid, input param_t, output ready);
endinterface

// ----- hw/rtl/qbe_out_if.sv -----
`timescale 1ns / 1ps

interface qbe_out_if;
  import qbe_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [PT_W-1:0]    curve_value;
  logic signed [SLOPE_W-1:0] curve_slope;

  modport source (output valid, output curve_value, output curve_slope, input ready);
  modport sink   (input valid, input curve_value, input curve_slope, output ready);
endinterface

// ----- hw/rtl/qbe_pow_cell.sv -----
`timescale 1ns / 1ps

module qbe_pow_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  qbe_pkg::pow_stage_t stage_i,
  output logic                valid_o,
  output qbe_pkg::pow_stage_t stage_o
);
  import qbe_pkg::*;

  logic       valid_q;
  pow_stage_t stage_d, stage_q;

  always_comb begin
    stage_d   = stage_i;
    stage_d.tp[0] = umul_round(stage_i.tp[0], stage_i.t);
    stage_d.up[0] = umul_round(stage_i.up[0], stage_i.u);
    for (int i = 1; i < NUM_PTS; i++) begin
      stage_d.tp[i] = stage_i.tp[i-1];
      stage_d.up[i] = stage_i.up[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ----- hw/rtl/qbe_blend.sv -----
`timescale 1ns / 1ps

module qbe_blend (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               valid_i,
  input  qbe_pkg::pow_stage_t                stage_i,
  input  qbe_pkg::pts_t                      points_i,
  output logic                               valid_o,
  output logic signed [qbe_pkg::PT_W-1:0]    value_o,
  output logic signed [qbe_pkg::SLOPE_W-1:0] slope_o
);
  import qbe_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF      = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] VAL_MAX   = (ACC_W'(1) <<< (PT_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] VAL_MIN   = -(ACC_W'(1) <<< (PT_W - 1));
  localparam logic signed [ACC_W-1:0] SLOPE_MAX = (ACC_W'(1) <<< (SLOPE_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SLOPE_MIN = -(ACC_W'(1) <<< (SLOPE_W - 1));

  logic [BLEND_STAGES-1:0] vld_q;

  pow_t                     bv_q [NUM_PTS];
  pow_t                     bd_q [NUM_PTS-1];
  logic [WGT_W-1:0]         wv_q [NUM_PTS];
  logic [WGT_W-1:0]         wd_q [NUM_PTS-1];
  logic signed [PROD_W-1:0] pv_q [NUM_PTS];
  logic signed [PROD_W-1:0] pd_q [NUM_PTS-1];
  logic signed [ACC_W-1:0]  sv_q [3];
  logic signed [ACC_W-1:0]  sd_q [3];
  logic signed [ACC_W-1:0]  av_q, ad_q, av2_q, ad5_q;
  logic signed [ACC_W-1:0]  rv, rs;
  logic signed [PT_W-1:0]    value_d, value_q;
  logic signed [SLOPE_W-1:0] slope_d, slope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[BLEND_STAGES-2:0], valid_i};
    end
  end

  // round and saturate the final sums
  always_comb begin
    rv = (av2_q + HALF) >>> FRAC_BITS;
    rs = (ad5_q + HALF) >>> FRAC_BITS;
    if (rv > VAL_MAX) begin
      value_d = VAL_MAX[PT_W-1:0];
    end else if (rv < VAL_MIN) begin
      value_d = VAL_MIN[PT_W-1:0];
    end else begin
      value_d = rv[PT_W-1:0];
    end
    if (rs > SLOPE_MAX) begin
      slope_d = SLOPE_MAX[SLOPE_W-1:0];
    end else if (rs < SLOPE_MIN) begin
      slope_d = SLOPE_MIN[SLOPE_W-1:0];
    end else begin
      slope_d = rs[SLOPE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // basis: t^k is at tp[5-k], u^j at up[5-j]
      for (int k = 0; k < NUM_PTS; k++) begin
        bv_q[k] <= umul_round(stage_i.tp[NUM_PTS-1-k], stage_i.up[k]);
        wv_q[k] <= {4'b0, bv_q[k]} * WGT_W'(BINOM5[k]);
        pv_q[k] <= PROD_W'($signed({1'b0, wv_q[k]})) * PROD_W'($signed(points_i[k]));
      end
      for (int k = 0; k < NUM_PTS - 1; k++) begin
        bd_q[k] <= umul_round(stage_i.tp[NUM_PTS-1-k], stage_i.up[k+1]);
        wd_q[k] <= {4'b0, bd_q[k]} * WGT_W'(BINOM4[k]);
        pd_q[k] <= PROD_W'($signed({1'b0, wd_q[k]}))
                 * (PROD_W'($signed(points_i[k+1])) - PROD_W'($signed(points_i[k])));
      end
      sv_q[0] <= ACC_W'(pv_q[0]) + ACC_W'(pv_q[1]);
      sv_q[1] <= ACC_W'(pv_q[2]) + ACC_W'(pv_q[3]);
      sv_q[2] <= ACC_W'(pv_q[4]) + ACC_W'(pv_q[5]);
      sd_q[0] <= ACC_W'(pd_q[0]) + ACC_W'(pd_q[1]);
      sd_q[1] <= ACC_W'(pd_q[2]) + ACC_W'(pd_q[3]);
      sd_q[2] <= ACC_W'(pd_q[4]);
      av_q    <= sv_q[0] + sv_q[1] + sv_q[2];
      ad_q    <= sd_q[0] + sd_q[1] + sd_q[2];
      av2_q   <= av_q;
      ad5_q   <= (ad_q <<< 2) + ad_q;
      value_q <= value_d;
      slope_q <= slope_d;
    end
  end

  assign valid_o = vld_q[BLEND_STAGES-1];
  assign value_o = value_q;
  assign slope_o = slope_q;

endmodule

// ----- hw/rtl/quintic_bezier_eval.sv -----
// Quintic Bezier segment evaluator: curve value and slope for each t word.
// Pipeline from input acceptance to result valid: 5 power cells, 7 blend
// stages and an output register. Throughput: one word per cycle; the
// pipeline holds only while its last stage is full and the output word waits.
// Reset: asynchronous, clears all six control points to zero and empties the pipeline.
`timescale 1ns / 1ps
`include "quintic_bezier_eval_macros.svh"

module quintic_bezier_eval (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [qbe_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [qbe_pkg::PT_W-1:0]          cfg_wdata_i,
  qbe_in_if.sink                            in_if,
  qbe_out_if.source                         out_if
);
  import qbe_pkg::*;

  pts_t       point_q;
  pow_stage_t chain_s [NUM_CELLS+1];
  logic       chain_v [NUM_CELLS+1];
  pow_t       t_sat;

  logic                      adv;
  logic                      blend_valid;
  logic signed [PT_W-1:0]    blend_value;
  logic signed [SLOPE_W-1:0] blend_slope;

  logic                      out_valid_q;
  logic signed [PT_W-1:0]    out_value_q;
  logic signed [SLOPE_W-1:0] out_slope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_PTS))) begin
      point_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // t above one saturates to one
  assign t_sat = (POW_W'(in_if.param_t) > ONE) ? ONE : POW_W'(in_if.param_t);

  always_comb begin
    chain_s[0].t  = t_sat;
    chain_s[0].u  = ONE - t_sat;
    chain_s[0].tp = '0;
    chain_s[0].up = '0;
    chain_s[0].tp[0] = ONE;
    chain_s[0].up[0] = ONE;
    chain_v[0] = in_if.valid;
  end

  assign adv         = !blend_valid || !out_valid_q || out_if.ready;
  assign in_if.ready = adv;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    qbe_pow_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (chain_v[i]),
      .stage_i (chain_s[i]),
      .valid_o (chain_v[i+1]),
      .stage_o (chain_s[i+1])
    );
  end

  qbe_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (chain_v[NUM_CELLS]),
    .stage_i  (chain_s[NUM_CELLS]),
    .points_i (point_q),
    .valid_o  (blend_valid),
    .value_o  (blend_value),
    .slope_o  (blend_slope)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && blend_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && blend_valid) begin
      out_value_q <= blend_value;
      out_slope_q <= blend_slope;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.curve_value = out_value_q;
  assign out_if.curve_slope = out_slope_q;

  `QBE_ASSERT_NEXT(a_accept_enters_chain, clk_i, rst_ni, in_if.valid && in_if.ready, chain_v[1])
  `QBE_ASSERT(a_stall_only_on_full_out, clk_i, rst_ni, !in_if.ready |-> out_valid_q && !out_if.ready)
  `QBE_ASSERT_NEXT(a_stall_holds_last, clk_i, rst_ni, blend_valid && !adv, blend_valid)
  `QBE_ASSERT_NEXT(a_drain_empties_out, clk_i, rst_ni, out_valid_q && out_if.ready && !blend_valid, !out_valid_q)

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import qbe_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT0, REG_POINT1, REG_POINT2, REG_POINT3, REG_POINT4, REG_POINT5,
    REG_SPARE6, REG_SPARE7
  } reg_idx_e;

  typedef struct packed {
    logic signed [PT_W-1:0]    value;
    logic signed [SLOPE_W-1:0] slope;
  } curve_sample_t;

  localparam longint ONE_Q       = longint'(1) <<< FRAC_BITS;
  localparam longint HALF_Q      = longint'(1) <<< (FRAC_BITS - 1);
  localparam longint VALUE_MAX   = 64'sd2147483647;
  localparam longint VALUE_MIN   = -64'sd2147483648;
  localparam longint SLOPE_MAX   = 64'sd34359738367;
  localparam longint SLOPE_MIN   = -64'sd34359738368;
  localparam int     SETTLE_CYC  = 40;
  localparam int     CYCLE_LIMIT = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [PT_W-1:0]     cfg_wdata_i;

  qbe_in_if  in_if ();
  qbe_out_if out_if ();

  quintic_bezier_eval u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  logic signed [PT_W-1:0] ctrl_pt [NUM_PTS];
  curve_sample_t          due_samples [$];
  int                     mismatches;
  int                     cycles;
  bit                     calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // x / 2^F, nearest, ties toward +inf
  function automatic longint qround(longint x);
    return (x + HALF_Q) >>> FRAC_BITS;
  endfunction

  function automatic curve_sample_t bezier_at(logic [T_W-1:0] t_raw);
    longint tv, uv, acc_v, acc_d, val, slope, w;
    longint tp [NUM_PTS];
    longint up [NUM_PTS];
    longint pk [NUM_PTS];
    curve_sample_t s;
    tv = (longint'(t_raw) > ONE_Q) ? ONE_Q : longint'(t_raw);
    uv = ONE_Q - tv;
    tp[0] = ONE_Q;
    up[0] = ONE_Q;
    for (int k = 1; k < NUM_PTS; k++) begin
      tp[k] = qround(tp[k-1] * tv);
      up[k] = qround(up[k-1] * uv);
    end
    for (int k = 0; k < NUM_PTS; k++) pk[k] = longint'(ctrl_pt[k]);
    acc_v = 0;
    for (int k = 0; k < NUM_PTS; k++) begin
      w = ((k == 0 || k == 5) ? 1 : (k == 1 || k == 4) ? 5 : 10) * qround(tp[k] * up[5-k]);
      acc_v += w * pk[k];
    end
    acc_d = 0;
    for (int k = 0; k < NUM_PTS - 1; k++) begin
      w = ((k == 0 || k == 4) ? 1 : (k == 1 || k == 3) ? 4 : 6) * qround(tp[k] * up[4-k]);
      acc_d += w * (pk[k+1] - pk[k]);
    end
    val = qround(acc_v);
    if (val > VALUE_MAX) val = VALUE_MAX;
    if (val < VALUE_MIN) val = VALUE_MIN;
    slope = qround(acc_d * 5);
    if (slope > SLOPE_MAX) slope = SLOPE_MAX;
    if (slope < SLOPE_MIN) slope = SLOPE_MIN;
    s.value = val[PT_W-1:0];
    s.slope = slope[SLOPE_W-1:0];
    return s;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    curve_sample_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_samples.size() == 0) begin
        $error("unexpected word: value %0d slope %0d", out_if.curve_value,
               out_if.curve_slope);
        mismatches++;
      end else begin
        want = due_samples.pop_front();
        if (out_if.curve_value !== want.value) begin
          $error("curve_value expected %0d actual %0d", want.value, out_if.curve_value);
          mismatches++;
        end
        if (out_if.curve_slope !== want.slope) begin
          $error("curve_slope expected %0d actual %0d", want.slope, out_if.curve_slope);
          mismatches++;
        end
      end
    end
  end

  // sink backpressure
  always @(negedge clk_i) begin
    out_if.ready <= calm || ($urandom_range(99) >= 32);
  end

  // entered and left at a falling edge
  task automatic send_t(input logic [T_W-1:0] t);
    while (!calm && $urandom_range(99) < 32) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.param_t <= t;
    do @(posedge clk_i); while (!in_if.ready);
    due_samples.push_back(bezier_at(t));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (due_samples.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [PT_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (int'(idx) < NUM_PTS) ctrl_pt[int'(idx)] = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_points(input pts_t pts);
    drain();
    for (int k = 0; k < NUM_PTS; k++) cfg_write(reg_idx_e'(k), pts[k]);
  endtask

  function automatic logic [PT_W-1:0] rand_point();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3, 4:    return PT_W'($urandom_range(2097152) - 1048576);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [T_W-1:0] rand_t();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return T_W'($urandom_range(65536));
    if (pick < 80) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return T_W'(1);
        2:       return T_W'(65535);
        default: return T_W'(65536);
      endcase
    end
    return T_W'($urandom_range(131071));
  endfunction

  task automatic test_reset_points();
    send_t(T_W'(0));
    send_t(T_W'(32768));
    send_t(T_W'(65536));
  endtask

  task automatic test_param_extremes();
    pts_t pts;
    pts[0] = -32'sd196608;
    pts[1] = 32'sd98304;
    pts[2] = 32'sd655360;
    pts[3] = -32'sd32769;
    pts[4] = 32'sd12345678;
    pts[5] = -32'sd1;
    load_points(pts);
    // above one saturates to 1.0
    send_t(T_W'(0));
    send_t(T_W'(1));
    send_t(T_W'(65535));
    send_t(T_W'(65536));
    send_t(T_W'(65537));
    send_t(T_W'(131071));
    send_t(T_W'(32768));
    send_t(T_W'(43690));
    send_t(T_W'(21845));
  endtask

  task automatic test_value_saturation();
    pts_t pts;
    for (int k = 0; k < NUM_PTS; k++) pts[k] = 32'h7fff_ffff;
    load_points(pts);
    send_t(T_W'(0));
    send_t(T_W'(1));
    send_t(T_W'(32768));
    send_t(T_W'(21845));
    for (int k = 0; k < NUM_PTS; k++) pts[k] = 32'h8000_0000;
    load_points(pts);
    send_t(T_W'(65535));
    send_t(T_W'(43690));
    send_t(T_W'(12345));
  endtask

  task automatic test_slope_extremes();
    pts_t pts;
    for (int k = 0; k < NUM_PTS; k++) pts[k] = k[0] ? 32'h7fff_ffff : 32'h8000_0000;
    load_points(pts);
    send_t(T_W'(0));
    send_t(T_W'(65536));
    send_t(T_W'(32768));
  endtask

  task automatic test_spare_index();
    pts_t pts;
    for (int k = 0; k < NUM_PTS; k++) pts[k] = rand_point();
    load_points(pts);
    // writes past the last point must leave the points alone
    cfg_write(REG_SPARE6, $urandom);
    cfg_write(REG_SPARE7, $urandom);
    send_t(T_W'(16384));
    send_t(T_W'(49152));
  endtask

  task automatic test_random_phases();
    pts_t pts;
    for (int ph = 0; ph < 7; ph++) begin
      for (int k = 0; k < NUM_PTS; k++) pts[k] = rand_point();
      load_points(pts);
      calm = (ph == 2);
      for (int n = 0; n < 150; n++) begin
        if (n == 75) drain();
        send_t(rand_t());
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_POINT0;
    cfg_wdata_i   = '0;
    in_if.valid   = 1'b0;
    in_if.param_t = '0;
    out_if.ready  = 1'b0;
    mismatches    = 0;
    cycles        = 0;
    calm          = 1'b0;
    for (int k = 0; k < NUM_PTS; k++) ctrl_pt[k] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_points();
    test_param_extremes();
    test_value_saturation();
    test_slope_extremes();
    test_spare_index();
    test_random_phases();
    drain();

    if (mismatches == 0 && due_samples.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/qbe_pkg.sv
hw/rtl/qbe_in_if.sv
hw/rtl/qbe_out_if.sv
hw/rtl/qbe_pow_cell.sv
hw/rtl/qbe_blend.sv
hw/rtl/quintic_bezier_eval.sv
tb/tb.sv
